[rtl/fads_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// fads_pkg
// Shared types and constants of the frame absolute difference statistics block.
// ============================================================================
package fads_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BORDER_MARGIN = 2'd2;

    localparam logic [12:0] FRAME_WIDTH_RESET   = 13'd640;
    localparam logic [12:0] FRAME_HEIGHT_RESET  = 13'd480;
    localparam logic [11:0] BORDER_MARGIN_RESET = 12'd0;

    // Width used for all position and dimension comparisons.
    localparam int CMP_W = 16;

    localparam int PIXEL_W = 8;
    localparam int COUNT_W = 25;
    localparam int SUM_W   = 32;
    localparam int MEAN_W  = 16;
    localparam int FRAC_W  = 8;
    localparam int DVD_W   = SUM_W + FRAC_W;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] pixel_count;
        logic [SUM_W-1:0]   sum_abs;
        logic [PIXEL_W-1:0] max_abs;
        logic [COUNT_W-1:0] over_one_count;
    } fads_summary_t;

endpackage

[rtl/frame_abs_difference_stats_top.sv]
`timescale 1ns / 1ps
// Pixel pairs are taken at one per cycle; only a full summary queue stops intake.
// After the frame's last pixel is taken, its summary passes through the queue to the
// 40-step restoring divider for the mean, one quotient bit a cycle, and is then
// loaded into the result word once that is empty or being popped. The divider takes
// one summary at a time from the queue. Reset returns the registers to 640 x 480 with
// no margin, clears positions and figures, and empties the queue and the output.
// ============================================================================
// frame_abs_difference_stats_top
// Absolute difference statistics over the interior window of two 8-bit frames.
// ============================================================================
module frame_abs_difference_stats_top
    import fads_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [PIXEL_W-1:0]     pixel_a,
    input  logic [PIXEL_W-1:0]     pixel_b,
    output logic                   empty,
    input  logic                   pop,
    output logic                   status,
    output logic [COUNT_W-1:0]     pixel_count,
    output logic [SUM_W-1:0]       sum_abs,
    output logic [PIXEL_W-1:0]     max_abs,
    output logic [COUNT_W-1:0]     over_one_count,
    output logic [MEAN_W-1:0]      mean_abs_q8
);

    logic          take, summary_valid, q_full, q_empty, q_pop;
    fads_summary_t summary, q_data, result;

    assign full = q_full;
    assign take = push && !q_full;

    fads_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .take          (take),
        .pixel_a       (pixel_a),
        .pixel_b       (pixel_b),
        .summary_valid (summary_valid),
        .summary       (summary)
    );

    fads_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (summary_valid),
        .wr_data (summary),
        .full    (q_full),
        .rd_en   (q_pop),
        .empty   (q_empty),
        .rd_data (q_data)
    );

    fads_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .result      (result),
        .mean_abs_q8 (mean_abs_q8)
    );

    assign status         = result.status;
    assign pixel_count    = result.pixel_count;
    assign sum_abs        = result.sum_abs;
    assign max_abs        = result.max_abs;
    assign over_one_count = result.over_one_count;

endmodule

[rtl/fads_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// fads_front
// Configuration registers, raster position tracking and per-pixel accumulation.
// ============================================================================
module fads_front
    import fads_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   take,
    input  logic [PIXEL_W-1:0]     pixel_a,
    input  logic [PIXEL_W-1:0]     pixel_b,
    output logic                   summary_valid,
    output fads_summary_t          summary
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] MAX_H_C = CMP_W'(MAX_HEIGHT);

    logic [12:0]        frame_width_reg;
    logic [12:0]        frame_height_reg;
    logic [11:0]        border_margin_reg;
    logic [COL_W-1:0]   column_pos_reg, column_pos_next;
    logic [ROW_W-1:0]   row_pos_reg, row_pos_next;
    logic [SUM_W-1:0]   diff_sum_reg, diff_sum_next;
    logic [PIXEL_W-1:0] diff_max_reg, diff_max_next;
    logic [COUNT_W-1:0] over_one_reg, over_one_next;
    logic [COUNT_W-1:0] compared_reg, compared_next;

    logic [CMP_W-1:0]   w_raw, h_raw, w_eff, h_eff, m_ext, m_twice, col_ext, row_ext;
    logic               no_interior, in_window, last, cfg_restart;
    logic [PIXEL_W-1:0] diff;

    assign w_raw   = CMP_W'(frame_width_reg);
    assign h_raw   = CMP_W'(frame_height_reg);
    assign w_eff   = (w_raw == '0) ? CMP_W'(1) : ((w_raw > MAX_W_C) ? MAX_W_C : w_raw);
    assign h_eff   = (h_raw == '0) ? CMP_W'(1) : ((h_raw > MAX_H_C) ? MAX_H_C : h_raw);
    assign m_ext   = CMP_W'(border_margin_reg);
    assign m_twice = m_ext << 1;
    assign col_ext = CMP_W'(column_pos_reg);
    assign row_ext = CMP_W'(row_pos_reg);

    assign no_interior = (w_eff <= m_twice) || (h_eff <= m_twice);
    assign in_window = !no_interior && (col_ext >= m_ext) && ((col_ext + m_ext) < w_eff)
                       && (row_ext >= m_ext) && ((row_ext + m_ext) < h_eff);
    assign last = (col_ext == w_eff - CMP_W'(1)) && (row_ext == h_eff - CMP_W'(1));
    assign diff = (pixel_a > pixel_b) ? (pixel_a - pixel_b) : (pixel_b - pixel_a);

    assign cfg_restart = cfg_write && ((cfg_index == CFG_FRAME_WIDTH)
                         || (cfg_index == CFG_FRAME_HEIGHT)
                         || (cfg_index == CFG_BORDER_MARGIN));

    always_comb
    begin
        diff_sum_next   = diff_sum_reg;
        diff_max_next   = diff_max_reg;
        over_one_next   = over_one_reg;
        compared_next   = compared_reg;
        column_pos_next = column_pos_reg;
        row_pos_next    = row_pos_reg;
        if (in_window)
        begin
            diff_sum_next = diff_sum_reg + SUM_W'(diff);
            if (diff > diff_max_reg)
            begin
                diff_max_next = diff;
            end
            if (diff > PIXEL_W'(1))
            begin
                over_one_next = over_one_reg + COUNT_W'(1);
            end
            compared_next = compared_reg + COUNT_W'(1);
        end
        if (col_ext == w_eff - CMP_W'(1))
        begin
            column_pos_next = '0;
            row_pos_next    = row_pos_reg + ROW_W'(1);
        end
        else
        begin
            column_pos_next = column_pos_reg + COL_W'(1);
        end
    end

    // A frame with no interior, or whose count has wrapped to zero, reports zeroed figures.
    always_comb
    begin
        summary_valid = take && last;
        summary.status = no_interior;
        if (no_interior || (compared_next == '0))
        begin
            summary.pixel_count    = '0;
            summary.sum_abs        = '0;
            summary.max_abs        = '0;
            summary.over_one_count = '0;
        end
        else
        begin
            summary.pixel_count    = compared_next;
            summary.sum_abs        = diff_sum_next;
            summary.max_abs        = diff_max_next;
            summary.over_one_count = over_one_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= FRAME_WIDTH_RESET;
            frame_height_reg  <= FRAME_HEIGHT_RESET;
            border_margin_reg <= BORDER_MARGIN_RESET;
            column_pos_reg    <= '0;
            row_pos_reg       <= '0;
            diff_sum_reg      <= '0;
            diff_max_reg      <= '0;
            over_one_reg      <= '0;
            compared_reg      <= '0;
        end
        else if (cfg_restart)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data;
                CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data;
                CFG_BORDER_MARGIN: border_margin_reg <= cfg_data[11:0];
                default:           frame_width_reg   <= frame_width_reg;
            endcase
            column_pos_reg <= '0;
            row_pos_reg    <= '0;
            diff_sum_reg   <= '0;
            diff_max_reg   <= '0;
            over_one_reg   <= '0;
            compared_reg   <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                column_pos_reg <= '0;
                row_pos_reg    <= '0;
                diff_sum_reg   <= '0;
                diff_max_reg   <= '0;
                over_one_reg   <= '0;
                compared_reg   <= '0;
            end
            else
            begin
                column_pos_reg <= column_pos_next;
                row_pos_reg    <= row_pos_next;
                diff_sum_reg   <= diff_sum_next;
                diff_max_reg   <= diff_max_next;
                over_one_reg   <= over_one_next;
                compared_reg   <= compared_next;
            end
        end
    end

endmodule

[rtl/fads_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// fads_queue
// Short queue of frame summaries between the accumulating front and the divider.
// ============================================================================
module fads_queue
    import fads_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  fads_summary_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic          empty,
    output fads_summary_t rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    fads_summary_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W:0]         fill_reg;
    logic                   do_wr, do_rd;

    assign full    = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + (PTR_W+1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule

[rtl/fads_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// fads_back
// Restoring divider for the rounded mean, followed by the result word register.
// ============================================================================
module fads_back
    import fads_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  fads_summary_t       q_data,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output fads_summary_t       result,
    output logic [MEAN_W-1:0]   mean_abs_q8
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;
    localparam int STEP_W = $clog2(DVD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

    logic [1:0]          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    fads_summary_t       work_reg;
    logic [DVD_W-1:0]    dvd_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [MEAN_W-1:0]   quo_reg;
    logic                out_valid_reg;
    fads_summary_t       out_reg;
    logic [MEAN_W-1:0]   out_mean_reg;

    logic [COUNT_W:0]    rem_shift, rem_sub;
    logic                fits, load_out, pop_take;

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign pop_take = pop && out_valid_reg;
    assign load_out = (state_reg == ST_HOLD) && (!out_valid_reg || pop);

    // One quotient bit per cycle, most significant first; only the low bits are kept.
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, work_reg.pixel_count};
    assign fits      = (rem_shift >= {1'b0, work_reg.pixel_count});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_data.pixel_count == '0) ? ST_HOLD : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            work_reg <= q_data;
            dvd_reg  <= {q_data.sum_abs, FRAC_W'(0)}
                        + DVD_W'(q_data.pixel_count[COUNT_W-1:1]);
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= fits ? rem_sub[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            quo_reg <= {quo_reg[MEAN_W-2:0], fits};
        end
        if (load_out)
        begin
            out_reg      <= work_reg;
            out_mean_reg <= quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DIV)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            else
            begin
                step_reg <= '0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty       = !out_valid_reg;
    assign result      = out_reg;
    assign mean_abs_q8 = out_mean_reg;

endmodule
